// ----- sv/rcpc_pkg.sv -----
// Shared types and constants for the remote-control pulse controller.
// Holds the sequencer state type, result codes, register indexes and the
// command/status structs passed between the sequencer and the slot unit.
`default_nettype none

package rcpc_pkg;

	// Fixed field widths
	localparam int unsigned PT_W   = 16;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CNT_W  = 9;
	localparam int unsigned ERR_W  = 3;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned DATA_W = 16;

	// Result error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] ERR_CODE     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_POINT    = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BUSY     = 3'd3;
	localparam logic [ERR_W-1:0] ERR_NO_TIMER = 3'd4;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [IDX_W-1:0] REG_PULSE_TICKS = 2'd1;
	localparam logic [IDX_W-1:0] REG_CLOSE_CODE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_OPEN_CODE   = 2'd3;

	// Register reset values
	localparam logic [CNT_W-1:0]  RST_POINT_COUNT = 9'd0;
	localparam logic [TICK_W-1:0] RST_PULSE_TICKS = 16'd5000;
	localparam logic [CODE_W-1:0] RST_CLOSE_CODE  = 8'd1;
	localparam logic [CODE_W-1:0] RST_OPEN_CODE   = 8'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT,
		ST_TICK,
		ST_FLUSH
	} rcpc_state_t;

	// Write commands from the sequencer to the addressed timer slot
	typedef struct packed {
		logic start;
		logic dec;
		logic expire;
		logic is_open;
	} slot_cmd_t;

	// Status of the addressed timer slot
	typedef struct packed {
		logic active;
		logic is_open;
		logic hit;
		logic expire;
	} slot_stat_t;

endpackage

`default_nettype wire

// ----- sv/rcpc_slot_unit.sv -----
// Timer slot store with one shared compare and decrement unit.
// One slot is addressed per cycle; depends on rcpc_pkg.
`default_nettype none

module rcpc_slot_unit
	import rcpc_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = 4,
	parameter int unsigned PW = 8,
	parameter int unsigned SW = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SW-1:0]     addr,
	input  wire slot_cmd_t         cmd,
	input  wire logic [PT_W-1:0]   pt,
	input  wire logic [TICK_W-1:0] load_ticks,
	output slot_stat_t             stat,
	output logic [PW-1:0]          slot_point
);

	logic [TIMER_SLOTS-1:0] active_q;
	logic [PW-1:0]          point_q  [TIMER_SLOTS];
	logic                   open_q   [TIMER_SLOTS];
	logic [TICK_W-1:0]      remain_q [TIMER_SLOTS];

	logic [TICK_W-1:0] remain_sel;
	logic [TICK_W-1:0] remain_dec;

	// Read the addressed slot and run the shared compare/decrement
	always_comb begin
		remain_sel   = remain_q[addr];
		remain_dec   = remain_sel - TICK_W'(1);
		slot_point   = point_q[addr];
		stat.active  = active_q[addr];
		stat.is_open = open_q[addr];
		stat.hit     = active_q[addr] && ({{(PT_W-PW){1'b0}}, point_q[addr]} == pt);
		stat.expire  = active_q[addr] && (remain_sel[TICK_W-1:1] == '0);
	end

	// Slot busy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.start) begin
			active_q[addr] <= 1'b1;
		end else if (cmd.expire) begin
			active_q[addr] <= 1'b0;
		end
	end

	// Slot payload: point, action and countdown
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			point_q[addr]  <= pt[PW-1:0];
			open_q[addr]   <= cmd.is_open;
			remain_q[addr] <= load_ticks;
		end else if (cmd.dec) begin
			remain_q[addr] <= remain_dec;
		end else if (cmd.expire) begin
			remain_q[addr] <= '0;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rcpc_seq.sv -----
// Sequencer of the pulse controller: takes orders and ticks, walks the
// timer slots through rcpc_slot_unit and holds the result register.
// Depends on rcpc_pkg.
`default_nettype none

module rcpc_seq
	import rcpc_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = 4,
	parameter int unsigned MAX_POINTS = 256,
	parameter int unsigned PW = 8,
	parameter int unsigned SW = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [PT_W-1:0]   point,
	input  wire logic [CODE_W-1:0] value_code,
	input  wire logic [CODE_W-1:0] value_inverse,
	// configuration
	input  wire logic [CNT_W-1:0]  point_count,
	input  wire logic [TICK_W-1:0] pulse_ticks,
	input  wire logic [CODE_W-1:0] close_code,
	input  wire logic [CODE_W-1:0] open_code,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   accepted,
	output logic [ERR_W-1:0]       error_code,
	output logic [PT_W-1:0]        point_echo,
	output logic                   pulse_ended,
	output logic                   close_drive,
	output logic                   open_drive,
	output logic                   last,
	// slot unit
	output logic [SW-1:0]          slot_addr,
	output slot_cmd_t              slot_cmd,
	output logic [PT_W-1:0]        slot_pt,
	output logic [TICK_W-1:0]      slot_ticks,
	input  wire slot_stat_t        slot_stat,
	input  wire logic [PW-1:0]     slot_point
);

	localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);
	localparam logic [CNT_W+PT_W-1:0] MAX_PT_L = (CNT_W+PT_W)'(MAX_POINTS);

	rcpc_state_t state_q, state_d;

	logic [SW-1:0]     idx_q;
	logic [PT_W-1:0]   pt_q;
	logic [CODE_W-1:0] code_q;
	logic [CODE_W-1:0] inv_q;
	logic              hit_q;
	logic              hit_open_q;
	logic              free_found_q;
	logic [SW-1:0]     free_idx_q;
	logic              pend_q;
	logic [PW-1:0]     pend_point_q;

	logic              out_valid_q;
	logic              acc_q;
	logic [ERR_W-1:0]  err_q;
	logic [PT_W-1:0]   echo_q;
	logic              ended_q;
	logic              cl_q;
	logic              op_q;
	logic              last_q;

	logic              out_free;
	logic              out_load;
	logic              ld_acc;
	logic [ERR_W-1:0]  ld_err;
	logic [PT_W-1:0]   ld_echo;
	logic              ld_ended;
	logic              ld_cl;
	logic              ld_op;
	logic              ld_last;
	logic              advance;
	logic              tick_go;

	logic                   is_close;
	logic                   is_open;
	logic                   code_ok;
	logic [CNT_W+PT_W-1:0]  limit;
	logic                   range_ok;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign slot_pt    = pt_q;
	assign slot_ticks = (pulse_ticks == '0) ? TICK_W'(1) : pulse_ticks;

	// Order checks on the captured transaction
	always_comb begin
		is_close = (code_q == close_code);
		is_open  = (code_q == open_code) && !is_close;
		code_ok  = (code_q == ~inv_q) && (is_close || is_open);
		limit    = ((CNT_W+PT_W)'(point_count) < MAX_PT_L) ?
			(CNT_W+PT_W)'(point_count) : MAX_PT_L;
		range_ok = ((CNT_W+PT_W)'(pt_q) < limit);
	end

	// Hold off the tick walk when a second expiry finds the result register full
	assign tick_go = !(slot_stat.expire && pend_q && !out_free);

	// Next state, slot commands and result loads
	always_comb begin
		state_d   = state_q;
		slot_addr = idx_q;
		slot_cmd  = '0;
		out_load  = 1'b0;
		ld_acc    = 1'b0;
		ld_err    = ERR_NONE;
		ld_echo   = pt_q;
		ld_ended  = 1'b0;
		ld_cl     = 1'b0;
		ld_op     = 1'b0;
		ld_last   = 1'b1;
		advance   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = command ? ST_TICK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				advance = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				slot_addr = free_idx_q;
				if (hit_q) begin
					ld_cl = !hit_open_q;
					ld_op = hit_open_q;
				end
				if (!code_ok) begin
					ld_err = ERR_CODE;
				end else if (!range_ok) begin
					ld_err = ERR_POINT;
				end else if (hit_q) begin
					ld_err = ERR_BUSY;
				end else if (!free_found_q) begin
					ld_err = ERR_NO_TIMER;
				end else begin
					ld_acc = 1'b1;
					ld_cl  = !is_open;
					ld_op  = is_open;
				end
				if (out_free) begin
					out_load         = 1'b1;
					slot_cmd.start   = ld_acc;
					slot_cmd.is_open = is_open;
					state_d          = ST_IDLE;
				end
			end
			ST_TICK: begin
				ld_echo  = {{(PT_W-PW){1'b0}}, pend_point_q};
				ld_ended = 1'b1;
				ld_last  = 1'b0;
				if (tick_go) begin
					advance = 1'b1;
					if (slot_stat.expire) begin
						slot_cmd.expire = 1'b1;
						out_load        = pend_q;
					end else if (slot_stat.active) begin
						slot_cmd.dec = 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_d = (pend_q || slot_stat.expire) ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				ld_echo  = {{(PT_W-PW){1'b0}}, pend_point_q};
				ld_ended = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan index and per-transaction flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_q       <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			if (advance && idx_q != LAST_IDX) begin
				idx_q <= idx_q + SW'(1);
			end
			if (state_q == ST_SCAN) begin
				if (slot_stat.hit) begin
					hit_q <= 1'b1;
				end
				if (!slot_stat.active && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == ST_TICK && tick_go && slot_stat.expire) begin
				pend_q <= 1'b1;
			end
			if (state_q == ST_FLUSH && out_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Captured transaction and scan payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pt_q   <= point;
			code_q <= value_code;
			inv_q  <= value_inverse;
		end
		if (state_q == ST_SCAN) begin
			if (slot_stat.hit) begin
				hit_open_q <= slot_stat.is_open;
			end
			if (!slot_stat.active && !free_found_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (state_q == ST_TICK && tick_go && slot_stat.expire) begin
			pend_point_q <= slot_point;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			acc_q   <= ld_acc;
			err_q   <= ld_err;
			echo_q  <= ld_echo;
			ended_q <= ld_ended;
			cl_q    <= ld_cl;
			op_q    <= ld_op;
			last_q  <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = acc_q;
	assign error_code  = err_q;
	assign point_echo  = echo_q;
	assign pulse_ended = ended_q;
	assign close_drive = cl_q;
	assign open_drive  = op_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- sv/remote_control_pulse_controller.sv -----
// Top level of the remote-control pulse controller: configuration registers,
// sequencer and timer slot unit. Depends on rcpc_pkg, rcpc_slot_unit, rcpc_seq.
`default_nettype none

// Takes one transaction at a time and stalls its input until the work is done.
// An order is accepted, then each timer slot is visited in turn to
// look for a pulse already running on the point and for the lowest free slot,
// and then the result is written. A tick walks every slot in turn through the
// shared countdown unit, with one more step to deliver the final expiry when
// any slot runs out. A stall on the output can hold the result step, the tick
// walk and the final expiry. Drive bits are not
// stored per point: at most one pulse runs on a point, so a point's close and
// open bits are read from the timer slot that holds it, and a point with no
// running pulse reads as zero. Configuration writes take effect the next cycle
// and belong to idle periods only.
module remote_control_pulse_controller
	import rcpc_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = 4,
	parameter int unsigned MAX_POINTS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_write,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [PT_W-1:0]   point,
	input  wire logic [CODE_W-1:0] value_code,
	input  wire logic [CODE_W-1:0] value_inverse,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   accepted,
	output logic [ERR_W-1:0]       error_code,
	output logic [PT_W-1:0]        point_echo,
	output logic                   pulse_ended,
	output logic                   close_drive,
	output logic                   open_drive,
	output logic                   last
);

	localparam int unsigned PW = $clog2(MAX_POINTS);
	localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic [CNT_W-1:0]  point_count_q;
	logic [TICK_W-1:0] pulse_ticks_q;
	logic [CODE_W-1:0] close_code_q;
	logic [CODE_W-1:0] open_code_q;

	logic [SW-1:0]     slot_addr;
	slot_cmd_t         slot_cmd;
	logic [PT_W-1:0]   slot_pt;
	logic [TICK_W-1:0] slot_ticks;
	slot_stat_t        slot_stat;
	logic [PW-1:0]     slot_point;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= RST_POINT_COUNT;
			pulse_ticks_q <= RST_PULSE_TICKS;
			close_code_q  <= RST_CLOSE_CODE;
			open_code_q   <= RST_OPEN_CODE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
				REG_PULSE_TICKS: pulse_ticks_q <= cfg_data[TICK_W-1:0];
				REG_CLOSE_CODE:  close_code_q  <= cfg_data[CODE_W-1:0];
				REG_OPEN_CODE:   open_code_q   <= cfg_data[CODE_W-1:0];
				default:         point_count_q <= point_count_q;
			endcase
		end
	end

	rcpc_seq #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.MAX_POINTS  (MAX_POINTS),
		.PW          (PW),
		.SW          (SW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.point         (point),
		.value_code    (value_code),
		.value_inverse (value_inverse),
		.point_count   (point_count_q),
		.pulse_ticks   (pulse_ticks_q),
		.close_code    (close_code_q),
		.open_code     (open_code_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.error_code    (error_code),
		.point_echo    (point_echo),
		.pulse_ended   (pulse_ended),
		.close_drive   (close_drive),
		.open_drive    (open_drive),
		.last          (last),
		.slot_addr     (slot_addr),
		.slot_cmd      (slot_cmd),
		.slot_pt       (slot_pt),
		.slot_ticks    (slot_ticks),
		.slot_stat     (slot_stat),
		.slot_point    (slot_point)
	);

	rcpc_slot_unit #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.PW          (PW),
		.SW          (SW)
	) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.addr       (slot_addr),
		.cmd        (slot_cmd),
		.pt         (slot_pt),
		.load_ticks (slot_ticks),
		.stat       (slot_stat),
		.slot_point (slot_point)
	);

`ifndef NO_ASSERTIONS
	// An accepted transaction always keeps the block busy for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while the sequencer stayed idle");

	// A started pulse reports no error and is never an expiry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> error_code == ERR_NONE && !pulse_ended && last)
		else $error("accepted order carries an error or expiry mark");

	// An expired pulse leaves both drive bits of its point clear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_ended |-> !close_drive && !open_drive && !accepted)
		else $error("expiry result reports a live drive bit");

	// A point is never driven close and open at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(close_drive && open_drive))
		else $error("close and open drive both set");
`endif

endmodule

`default_nettype wire
